@@ hw/rtl/mpkt_pkg.sv @@
package mpkt_pkg;

  localparam int MAX_TRADES = 16;
  localparam int PRICE_W    = 16;
  localparam int PROFIT_W   = 26;
  localparam int COST_W     = 28;
  localparam int LIMIT_W    = 5;
  localparam int LANE_W     = $clog2(MAX_TRADES + 1);
  localparam int SEL_W      = (LANE_W > LIMIT_W) ? LANE_W : LIMIT_W;

  localparam logic [PROFIT_W-1:0] PROFIT_MAX = {PROFIT_W{1'b1}};

  localparam logic [2:0] ADDR_TRADE_LIMIT = 3'd0;
  localparam logic [2:0] ADDR_UNLIMITED   = 3'd4;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic               step;
    logic               first;
    logic [PRICE_W-1:0] price;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/max_profit_k_trades_top.sv @@
// Best k-transaction trading profit over a price stream, one result per price.
// Each accepted price is registered into the cells and a pending flag; the result is then
// registered into the output once that register is free. Throughput: one price per cycle while
// the output is not stalled; every transaction cell updates in parallel from its neighbor's registered profit.
// Reset (rst, synchronous, active high) clears all cells, the rise total and the
// output valid flag, and sets trade_limit to 1 and unlimited_mode to 0.
module max_profit_k_trades_top
  import mpkt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Price requests.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] price
  input  logic        s_tlast,   // last_day
  // Result requests.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [25:0] best_profit, [31:26] zero
  output logic        m_tlast,   // sequence_end
  // Configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LIMIT_W-1:0]  trade_limit;
  logic                unlimited_mode;
  logic                first_pending;
  logic                pend;
  logic                pend_last;
  logic [PRICE_W-1:0]  previous_price;
  logic [PROFIT_W-1:0] rise_total;
  logic [PROFIT_W-1:0] rise_next;
  logic [PROFIT_W:0]   rise_sum;
  logic                accept;
  logic                out_free;
  cell_ctrl_t          ctrl;
  logic [PROFIT_W-1:0] profits [0:MAX_TRADES];
  logic [SEL_W-1:0]    limit_ext;
  logic [LANE_W-1:0]   lane;
  logic [PROFIT_W-1:0] best;

  assign pready   = 1'b1;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !pend || out_free;
  assign accept   = s_tvalid && s_tready;

  assign ctrl.step  = accept;
  assign ctrl.first = first_pending;
  assign ctrl.price = s_tdata;

  assign profits[0] = '0;

  for (genvar t = 1; t <= MAX_TRADES; t++) begin : g_cell
    mpkt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .prev_profit (profits[t-1]),
      .profit      (profits[t])
    );
  end

  // Rise total for unlimited mode.
  always_comb begin
    rise_sum  = {1'b0, rise_total} + {{(PROFIT_W+1-PRICE_W){1'b0}}, s_tdata - previous_price};
    rise_next = rise_total;
    if (s_tdata > previous_price) begin
      rise_next = rise_sum[PROFIT_W] ? PROFIT_MAX : rise_sum[PROFIT_W-1:0];
    end
  end

  // Lane select, with limits beyond the cell count clamped to the last cell.
  always_comb begin
    limit_ext = SEL_W'(trade_limit);
    if (limit_ext >= SEL_W'(MAX_TRADES)) begin
      lane = LANE_W'(MAX_TRADES);
    end else begin
      lane = limit_ext[LANE_W-1:0];
    end
    best = unlimited_mode ? rise_total : profits[lane];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending  <= 1'b1;
      pend           <= 1'b0;
      m_tvalid       <= 1'b0;
      rise_total     <= '0;
      previous_price <= '0;
    end else begin
      if (accept) begin
        first_pending  <= s_tlast;
        previous_price <= s_tdata;
        rise_total     <= first_pending ? '0 : rise_next;
        pend           <= 1'b1;
      end else if (out_free) begin
        pend <= 1'b0;
      end
      if (pend && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_last <= s_tlast;
    end
    if (pend && out_free) begin
      m_tdata <= {{(32-PROFIT_W){1'b0}}, best};
      m_tlast <= pend_last;
    end
  end

  // Configuration registers; only paddr[2] selects between them.
  always_ff @(posedge clk) begin
    if (rst) begin
      trade_limit    <= LIMIT_W'(1);
      unlimited_mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == ADDR_UNLIMITED[2]) begin
        unlimited_mode <= pwdata[0];
      end else begin
        trade_limit <= pwdata[LIMIT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ADDR_TRADE_LIMIT[2]) begin
      prdata = {{(32-LIMIT_W){1'b0}}, trade_limit};
    end else begin
      prdata = {31'b0, unlimited_mode};
    end
  end

endmodule

@@ hw/rtl/mpkt_cell.sv @@
module mpkt_cell
  import mpkt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cell_ctrl_t          ctrl,
  input  logic [PROFIT_W-1:0] prev_profit,
  output logic [PROFIT_W-1:0] profit
);

  logic signed [COST_W-1:0] lowest;
  logic signed [COST_W-1:0] cand;
  logic signed [COST_W-1:0] lowest_next;
  logic signed [COST_W:0]   gain;
  logic [PROFIT_W-1:0]      gain_sat;
  logic [PROFIT_W-1:0]      profit_next;

  // prev_profit is the neighbor's value from the previous item, which gives
  // the descending-count order of the update.
  always_comb begin
    cand = $signed({{(COST_W-PRICE_W){1'b0}}, ctrl.price})
         - $signed({{(COST_W-PROFIT_W){1'b0}}, prev_profit});
    lowest_next = (cand < lowest) ? cand : lowest;
    gain = $signed({{(COST_W+1-PRICE_W){1'b0}}, ctrl.price})
         - $signed({lowest_next[COST_W-1], lowest_next});
    if (gain < 0) begin
      gain_sat = '0;
    end else if (gain > $signed({3'b000, PROFIT_MAX})) begin
      gain_sat = PROFIT_MAX;
    end else begin
      gain_sat = gain[PROFIT_W-1:0];
    end
    profit_next = (gain_sat > profit) ? gain_sat : profit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest <= '0;
      profit <= '0;
    end else if (ctrl.step) begin
      if (ctrl.first) begin
        lowest <= $signed({{(COST_W-PRICE_W){1'b0}}, ctrl.price});
        profit <= '0;
      end else begin
        lowest <= lowest_next;
        profit <= profit_next;
      end
    end
  end

endmodule

@@ dv/tb.sv @@
module tb;
  import mpkt_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               last_day;
  } day_t;

  typedef struct packed {
    logic [PROFIT_W-1:0] profit;
    logic                seq_end;
  } quote_t;

  typedef enum int {STYLE_RANDOM, STYLE_WALK, STYLE_EXTREME, STYLE_LOW} price_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  max_profit_k_trades_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  day_t   pending_days[$];
  quote_t best_profit_q[$];
  int     errors = 0;
  int     src_wait = 0;
  int     snk_wait = 0;
  int     idle_cycles = 0;
  int     stretch_left[2] = '{0, 0};
  bit     calm[2] = '{1'b0, 1'b0};

  // Shadow of the trading state, one lane per allowed transaction count.
  logic signed [COST_W-1:0] low_cost [1:MAX_TRADES];
  logic [PROFIT_W-1:0]      lane_profit [0:MAX_TRADES];
  logic [PROFIT_W-1:0]      rise_sum = '0;
  logic [PRICE_W-1:0]       prev_price = '0;
  logic                     opening = 1'b1;
  logic [LIMIT_W-1:0]       cfg_limit = 5'd1;
  logic                     cfg_unlimited = 1'b0;

  // Stimulus generator state.
  int                 days_left = 0;
  logic [PRICE_W-1:0] gen_prev = '0;

  function automatic quote_t advance_day(day_t d);
    longint cand;
    longint gain;
    longint sum;
    int     lane;
    quote_t q;
    if (opening) begin
      for (int t = 1; t <= MAX_TRADES; t++) low_cost[t] = COST_W'(d.price);
      for (int t = 0; t <= MAX_TRADES; t++) lane_profit[t] = '0;
      rise_sum = '0;
      opening = 1'b0;
    end else begin
      // Walking down the lanes lets each one see the previous day's profit below it.
      for (int t = MAX_TRADES; t >= 1; t--) begin
        cand = longint'(d.price) - longint'(lane_profit[t-1]);
        if (cand < longint'(low_cost[t])) low_cost[t] = cand[COST_W-1:0];
        gain = longint'(d.price) - longint'(low_cost[t]);
        if (gain > longint'(PROFIT_MAX)) gain = longint'(PROFIT_MAX);
        if (gain < 0) gain = 0;
        if (gain > longint'(lane_profit[t])) lane_profit[t] = gain[PROFIT_W-1:0];
      end
      if (d.price > prev_price) begin
        sum = longint'(rise_sum) + longint'(d.price) - longint'(prev_price);
        if (sum > longint'(PROFIT_MAX)) sum = longint'(PROFIT_MAX);
        rise_sum = sum[PROFIT_W-1:0];
      end
    end
    prev_price = d.price;
    lane = (cfg_limit > MAX_TRADES) ? MAX_TRADES : int'(cfg_limit);
    q.profit = cfg_unlimited ? rise_sum : lane_profit[lane];
    q.seq_end = d.last_day;
    if (d.last_day) opening = 1'b1;
    return q;
  endfunction

  // Side 0 is the price source, side 1 the result sink.
  function automatic int pick_pause(int side);
    int r;
    if (stretch_left[side] == 0) begin
      stretch_left[side] = $urandom_range(8, 60);
      calm[side] = ($urandom_range(0, 2) == 0);
    end
    stretch_left[side]--;
    if (calm[side]) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  always @(posedge clk) begin : drive_days
    day_t d;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) best_profit_q.push_back(advance_day('{s_tdata, s_tlast}));
      if (!s_tvalid || s_tready) begin
        if (src_wait != 0) begin
          s_tvalid <= 1'b0;
          src_wait <= src_wait - 1;
        end else if (pending_days.size() != 0) begin
          d = pending_days.pop_front();
          s_tdata <= d.price;
          s_tlast <= d.last_day;
          s_tvalid <= 1'b1;
          src_wait <= pick_pause(0);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    quote_t want;
    if (rst) begin
      m_tready <= 1'b0;
      snk_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (best_profit_q.size() == 0) begin
          $display("%0t: unexpected result profit=%0d end=%0b", $time,
                   m_tdata[PROFIT_W-1:0], m_tlast);
          errors++;
        end else begin
          want = best_profit_q.pop_front();
          if (m_tdata[PROFIT_W-1:0] !== want.profit) begin
            $display("%0t: best_profit expected %0d actual %0d", $time, want.profit,
                     m_tdata[PROFIT_W-1:0]);
            errors++;
          end
          if (m_tlast !== want.seq_end) begin
            $display("%0t: sequence_end expected %0b actual %0b", $time, want.seq_end,
                     m_tlast);
            errors++;
          end
        end
        snk_wait = pick_pause(1);
      end
      if (snk_wait != 0) begin
        m_tready <= 1'b0;
        snk_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_day(input logic [PRICE_W-1:0] price, input logic last_day);
    pending_days.push_back('{price, last_day});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_days.size() != 0 || s_tvalid || best_profit_q.size() != 0);
  endtask

  task automatic apb_access(input logic [2:0] addr, input logic wr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_and_check(input logic [2:0] addr, input logic [31:0] wdata,
                                 input logic [31:0] keep_mask);
    logic [31:0] rd;
    apb_access(addr, 1'b1, wdata, rd);
    if (addr == ADDR_TRADE_LIMIT) cfg_limit = wdata[LIMIT_W-1:0];
    else if (addr == ADDR_UNLIMITED) cfg_unlimited = wdata[0];
    apb_access(addr, 1'b0, '0, rd);
    if (rd !== (wdata & keep_mask)) begin
      $display("%0t: register at %0d expected %h actual %h", $time, addr,
               wdata & keep_mask, rd);
      errors++;
    end
  endtask

  // Only called with nothing in flight; an open sequence may span the change.
  task automatic program_setting(input int limit, input bit unlimited);
    wait_drained();
    write_and_check(ADDR_TRADE_LIMIT, {$urandom_range(0, 1) ? 27'($urandom) : 27'd0,
                    5'(limit)}, 32'h1f);
    write_and_check(ADDR_UNLIMITED, {$urandom_range(0, 1) ? 31'($urandom) : 31'd0,
                    1'(unlimited)}, 32'h1);
  endtask

  task automatic queue_directed();
    push_day(16'hffff, 1'b1);
    push_day(16'd100, 1'b0);
    push_day(16'd50, 1'b0);
    push_day(16'd200, 1'b0);
    push_day(16'd10, 1'b0);
    push_day(16'd300, 1'b0);
    push_day(16'd0, 1'b0);
    push_day(16'hffff, 1'b1);
    push_day(16'd0, 1'b0);
    push_day(16'hffff, 1'b0);
    push_day(16'd0, 1'b0);
    push_day(16'hffff, 1'b1);
    push_day(16'd500, 1'b0);
    push_day(16'd400, 1'b0);
    push_day(16'd300, 1'b1);
    push_day(16'd7, 1'b0);
    push_day(16'd7, 1'b1);
    push_day(16'd40000, 1'b0);
    push_day(16'd39999, 1'b0);
    push_day(16'hfffe, 1'b1);
  endtask

  function automatic logic [PRICE_W-1:0] next_price(price_style_t style);
    int step;
    int p;
    case (style)
      STYLE_WALK: begin
        step = $urandom_range(0, 600);
        p = int'(gen_prev) + step - 300;
        if (p < 0) p = 0;
        if (p > 65535) p = 65535;
        return PRICE_W'(p);
      end
      STYLE_EXTREME: begin
        return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      end
      STYLE_LOW: begin
        return PRICE_W'($urandom_range(0, 31));
      end
      default: begin
        return PRICE_W'($urandom);
      end
    endcase
  endfunction

  task automatic queue_random(input int count);
    price_style_t style;
    int r;
    logic [PRICE_W-1:0] p;
    style = STYLE_RANDOM;
    for (int i = 0; i < count; i++) begin
      if (days_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 10) days_left = 1;
        else if (r < 85) days_left = $urandom_range(2, 20);
        else days_left = $urandom_range(40, 120);
        r = $urandom_range(0, 99);
        if (r < 35) style = STYLE_WALK;
        else if (r < 65) style = STYLE_RANDOM;
        else if (r < 85) style = STYLE_EXTREME;
        else style = STYLE_LOW;
        gen_prev = PRICE_W'($urandom);
      end
      days_left--;
      p = next_price(style);
      gen_prev = p;
      push_day(p, days_left == 0);
    end
  endtask

  initial begin
    int limits[8];
    limits = '{0, 1, 2, 15, 16, 17, 31, 0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset setting, then no trades, then an oversized limit, then unlimited.
    queue_directed();
    program_setting(0, 1'b0);
    queue_directed();
    program_setting(31, 1'b0);
    queue_directed();
    program_setting(2, 1'b1);
    queue_directed();

    // A full-swing sawtooth in unlimited mode; the sequence stays open across
    // the switch back to limited mode.
    program_setting(16, 1'b1);
    for (int i = 0; i < 20; i++) begin
      push_day(16'h0000, 1'b0);
      push_day(16'hffff, 1'b0);
    end
    program_setting(16, 1'b0);
    push_day(16'h0000, 1'b0);
    push_day(16'hffff, 1'b0);
    program_setting(3, 1'b0);
    push_day(16'h1234, 1'b1);

    days_left = 0;
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 7) program_setting(limits[ph], $urandom_range(0, 3) == 0);
      else program_setting($urandom_range(0, 31), $urandom_range(0, 3) == 0);
      queue_random(80);
    end
    if (days_left != 0) queue_random(days_left);

    wait_drained();
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
